// ----- design/lbss_pkg.sv -----
`timescale 1ns / 1ps
// lbss_pkg: shared types and constants of the led beat slot scheduler
// depends on nothing; used by the scheduler top level and its checker

package lbss_pkg;

   // item kind carried on req_tuser
   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_TICK   = 2'd1;
   localparam logic [1:0] FUNC_ADJUST = 2'd2;

   // configuration register word addresses
   localparam logic REG_BEAT_TICKS = 1'b0;

   localparam logic [7:0] BEAT_TIME_RESET = 8'd2;
   localparam logic [7:0] MIN_TICKS       = 8'd2;
   localparam logic [7:0] DOUBLE_DITHER_LIMIT = 8'd8;

   typedef struct packed {
      logic [7:0] value;
      logic [7:0] port;
      logic [7:0] dir;
   } slot_entry_type;

   // dither sequence 0, 3, 1, 2
   function automatic logic [1:0] next_dither(input logic [1:0] d);
      logic [1:0] t;
      t = d ^ 2'd2;
      if (t[1]) begin
         t = t ^ 2'd1;
      end
      return t;
   endfunction

endpackage

// ----- design/lbss_ram.sv -----
`timescale 1ns / 1ps
// lbss_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module lbss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/led_beat_slot_scheduler.sv -----
`timescale 1ns / 1ps
// led_beat_slot_scheduler: top level, multiplexed led time-slot scheduler
// path: a tick item reaches rsp through the ram read data register and then the result
//   register, and it waits in stage 1 while the result is stalled
// throughput: one item per cycle; the slot pointer feeds back into the ram read address
//   in the same cycle, and a stalled result holds the input off until it is taken
// reset: synchronous, clears pointer, beat time (to two), dither, beat counter, adjustment,
//   beat_ticks and the handshake state; slot entries stay undefined until written
// depends on lbss_pkg and lbss_ram

module led_beat_slot_scheduler
   import lbss_pkg::*;
#(
   parameter int SLOTS = 13
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] slot_index, [11:4] slot_dir, [19:12] slot_port, [27:20] slot_value,
   // [35:28] beat_adjust_in, [39:36] zero
   input  logic [39:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] port_bits, [15:8] led_dir, [16] led_blank, [24:17] compare_value,
   // [25] beat_started, [33:26] beat_count, [39:34] zero
   output logic [39:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(SLOTS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

   // input field split
   logic [1:0] req_func;
   logic [3:0] req_slot_index;
   slot_entry_type req_entry;
   logic [7:0] req_adjust;

   assign req_func          = req_tuser;
   assign req_slot_index    = req_tdata[3:0];
   assign req_entry.dir     = req_tdata[11:4];
   assign req_entry.port    = req_tdata[19:12];
   assign req_entry.value   = req_tdata[27:20];
   assign req_adjust        = req_tdata[35:28];

   // configuration register
   logic [7:0] beat_ticks_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_BEAT_TICKS) ? {24'd0, beat_ticks_ff} : 32'd0;

   // scheduler state
   logic [AW-1:0] ptr_ff;
   logic [7:0]    time_left_ff;
   logic [1:0]    dither_ff;
   logic [7:0]    beat_count_ff;
   logic [7:0]    adjust_ff;

   // stage 1: item waiting on the ram read data
   logic       s1_valid_ff;
   logic [1:0] s1_func_ff;
   logic [7:0] s1_adjust_ff;

   // result register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_port_ff;
   logic [7:0]  rsp_dir_ff;
   logic        rsp_blank_ff;
   logic [7:0]  rsp_compare_ff;
   logic        rsp_started_ff;
   logic [7:0]  rsp_count_ff;

   logic out_free;
   logic s1_advance;
   logic s1_tick;
   logic s1_tick_fire;
   logic req_accept;

   assign out_free     = ~rsp_valid_ff | rsp_tready;
   assign s1_tick      = s1_valid_ff & (s1_func_ff == FUNC_TICK);
   assign s1_advance   = ~s1_tick | out_free;
   assign s1_tick_fire = s1_tick & out_free;
   assign req_tready   = s1_advance;
   assign req_accept   = req_tvalid & req_tready;

   // slot memory: writes land at accept, tick reads issue at accept, so all
   // memory accesses stay in item order and never collide
   logic           ram_wr_en;
   logic           ram_rd_en;
   logic [AW-1:0]  ram_rd_addr;
   slot_entry_type ram_rd_data;
   logic [AW-1:0]  ptr_in;

   assign ram_wr_en = req_accept & (req_func == FUNC_WRITE)
                    & ({2'b00, req_slot_index} < 6'(SLOTS));
   assign ram_rd_en   = req_accept & (req_func == FUNC_TICK);
   assign ram_rd_addr = ptr_in;

   lbss_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_slot_index)),
      .wr_data (req_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // tick arithmetic on the slot just read
   logic [7:0] v;
   logic [7:0] dither8;
   logic [7:0] h_sum;
   logic [7:0] h_raw;
   logic       blank;
   logic [7:0] h_min;
   logic [7:0] h_clip;
   logic [7:0] time_after;
   logic       beat_end;
   logic       started;
   logic [AW-1:0] ptr_inc;
   logic [7:0] beat_count_in;
   logic [7:0] time_left_in;

   always_comb begin
      v       = ram_rd_data.value;
      dither8 = {6'd0, dither_ff};
      // small values get the dither twice
      h_sum   = v + ((v < DOUBLE_DITHER_LIMIT) ? dither8 : 8'd0) + dither8;
      h_raw   = h_sum >> 2;
      blank   = h_raw < MIN_TICKS;
      h_min   = blank ? MIN_TICKS : h_raw;
      // clip to the rest of the beat; the list terminator takes all of it
      h_clip  = ((h_min > time_left_ff) || (v == 8'd0)) ? time_left_ff : h_min;
      time_after = time_left_ff - h_clip;
      beat_end   = time_after < MIN_TICKS;
      started    = (ptr_ff == '0);
      ptr_inc    = (ptr_ff == LAST_SLOT) ? ptr_ff : AW'(ptr_ff + 1'b1);
      beat_count_in = started ? 8'(beat_count_ff + 8'd1) : beat_count_ff;
      time_left_in  = beat_end ? 8'(time_after + adjust_ff + beat_ticks_ff) : time_after;
      if (s1_tick_fire) begin
         ptr_in = beat_end ? '0 : ptr_inc;
      end else begin
         ptr_in = ptr_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ticks_ff <= 8'd0;
         ptr_ff        <= '0;
         time_left_ff  <= BEAT_TIME_RESET;
         dither_ff     <= 2'd0;
         beat_count_ff <= 8'd0;
         adjust_ff     <= 8'd0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == REG_BEAT_TICKS)) begin
            beat_ticks_ff <= csr_pwdata[7:0];
         end

         // only ticks and adjustments need stage 1
         if (s1_advance) begin
            s1_valid_ff <= req_accept
                         & ((req_func == FUNC_TICK) | (req_func == FUNC_ADJUST));
         end

         ptr_ff <= ptr_in;
         if (s1_tick_fire) begin
            time_left_ff  <= time_left_in;
            beat_count_ff <= beat_count_in;
            if (beat_end) begin
               adjust_ff <= 8'd0;
               dither_ff <= next_dither(dither_ff);
            end
         end else if (s1_valid_ff && (s1_func_ff == FUNC_ADJUST)) begin
            adjust_ff <= s1_adjust_ff;
         end

         if (s1_tick_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_func_ff   <= req_func;
         s1_adjust_ff <= req_adjust;
      end
      if (s1_tick_fire) begin
         rsp_port_ff    <= ram_rd_data.port;
         rsp_dir_ff     <= ram_rd_data.dir;
         rsp_blank_ff   <= blank;
         rsp_compare_ff <= h_clip - 8'd1;
         rsp_started_ff <= started;
         rsp_count_ff   <= beat_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_started_ff, rsp_compare_ff,
                        rsp_blank_ff, rsp_dir_ff, rsp_port_ff};

endmodule

// ----- design/lbss_checker.sv -----
`timescale 1ns / 1ps
// lbss_checker: port-level assertions for the led beat slot scheduler
// depends on lbss_pkg; bound to led_beat_slot_scheduler below

module lbss_checker
   import lbss_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_pready
);

   logic [7:0] last_count_ff;
   logic       rsp_take;
   logic       rsp_started;
   logic [7:0] rsp_count;

   assign rsp_take    = rsp_tvalid & rsp_tready;
   assign rsp_started = rsp_tdata[25];
   assign rsp_count   = rsp_tdata[33:26];

   // beat count of the last item delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= 8'd0;
      end else if (rsp_take) begin
         last_count_ff <= rsp_count;
      end
   end

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // no result right after a reset cycle
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // beat count steps by one exactly on items that start a beat
   a_beat_count: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_started ? (rsp_count == 8'(last_count_ff + 8'd1))
                                : (rsp_count == last_count_ff)))
      else $error("beat count out of step with beat_started");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready low");

endmodule

bind led_beat_slot_scheduler lbss_checker u_lbss_checker (.*);
